// ----- src/pid_pkg.sv -----
package pid_pkg;

    // Field and datapath widths
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int ACC_W     = 48;
    localparam int ST_W      = 31;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int OPA_W     = ACC_W + 1;
    localparam int OPB_W     = DATA_W;
    localparam int HALF_W    = FRAC_BITS + 1;
    localparam int PROD_W    = OPA_W + HALF_W;
    localparam int FULL_W    = OPA_W + OPB_W;
    localparam int TERM_W    = FULL_W - FRAC_BITS;
    localparam int SUM_W     = TERM_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_KP          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_OVER_TS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_MIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_MAX     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_START = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_START = 3'd7;

    localparam logic [ST_W-1:0] SAMPLE_TIME_RST = ST_W'(655);

    // Request commands
    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_LOAD    = 1'b1;

    // Saturation limits, held at the width of the running sum
    localparam logic signed [SUM_W-1:0] ACC_MAX  = {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN  = ~ACC_MAX;
    localparam logic signed [SUM_W-1:0] DATA_MAX =
        {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] DATA_MIN = ~DATA_MAX;

    // Step controls for the shared multiply unit
    typedef struct packed {
        logic lo_en;      // multiply by the low fraction half of operand B
        logic hi_en;      // multiply by the signed high half, park the low product
        logic combine_en; // fold the high product into the full product
    } mac_ctrl_t;

endpackage

// ----- src/pid_mac.sv -----
// Shared multiplier: forms the exact product of a 49-bit signed operand and a
// 32-bit signed operand in two 49x17 passes, then presents floor(a*b / 2^16).
module pid_mac (
    input  logic                               clk,
    input  pid_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [pid_pkg::OPA_W-1:0]   op_a,
    input  logic signed [pid_pkg::OPB_W-1:0]   op_b,
    output logic signed [pid_pkg::TERM_W-1:0]  term
);

    logic signed [pid_pkg::HALF_W-1:0] b_part;
    logic signed [pid_pkg::PROD_W-1:0] a_ext;
    logic signed [pid_pkg::PROD_W-1:0] b_ext;
    logic signed [pid_pkg::PROD_W-1:0] prod_next;
    logic signed [pid_pkg::PROD_W-1:0] prod_reg;
    logic signed [pid_pkg::FULL_W-1:0] prod_ext;
    logic signed [pid_pkg::FULL_W-1:0] full_reg;

    // Pick the half of operand B: low half is an unsigned fraction
    always_comb
    begin
        if (ctrl.hi_en)
        begin
            b_part = {op_b[pid_pkg::OPB_W-1], op_b[pid_pkg::OPB_W-1:pid_pkg::FRAC_BITS]};
        end
        else
        begin
            b_part = {1'b0, op_b[pid_pkg::FRAC_BITS-1:0]};
        end
    end

    // Sign-extend both operands to the product width
    assign a_ext = {{(pid_pkg::PROD_W-pid_pkg::OPA_W){op_a[pid_pkg::OPA_W-1]}}, op_a};
    assign b_ext = {{(pid_pkg::PROD_W-pid_pkg::HALF_W){b_part[pid_pkg::HALF_W-1]}}, b_part};

    assign prod_next = a_ext * b_ext;
    assign prod_ext  = {{(pid_pkg::FULL_W-pid_pkg::PROD_W){prod_reg[pid_pkg::PROD_W-1]}},
                        prod_reg};

    // Register each partial product, then accumulate the exact product
    always_ff @(posedge clk)
    begin
        if (ctrl.lo_en || ctrl.hi_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.hi_en)
        begin
            full_reg <= prod_ext;
        end
        else if (ctrl.combine_en)
        begin
            full_reg <= full_reg + (prod_ext <<< pid_pkg::FRAC_BITS);
        end
    end

    // Drop the fraction bits: floor division by 2^16
    assign term = full_reg[pid_pkg::FULL_W-1:pid_pkg::FRAC_BITS];

endmodule

// ----- src/pid_controller_step.sv -----
// One discrete PID step per request, signed Q16.16. A process request
// computes four products when the sample lies inside the integration window
// and three when it does not, skipping the integral increment; a load request
// uses no multiplier. The block returns to idle when the result is taken.
// All products go through the single shared 49x17 multiplier: each of the
// products (integral increment, derivative, proportional, integral terms)
// takes a low pass, a high pass and a combine step through it, and the terms
// are summed one at a time. in_stall stays high from acceptance until the
// result has been taken. Configuration registers may be written only while the block is idle.
module pid_controller_step (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic signed [pid_pkg::DATA_W-1:0]    error_sample,
    // Result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pid_pkg::DATA_W-1:0]    drive,
    output logic                                 integrated,
    output logic                                 clipped,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [pid_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pid_pkg::CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_FINISH,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        T_INC,
        T_D,
        T_P,
        T_I
    } term_kind_t;

    typedef enum logic [1:0] {
        PH_LO,
        PH_HI,
        PH_COMBINE
    } phase_t;

    // Configuration registers
    logic signed [pid_pkg::DATA_W-1:0] kp_reg;
    logic signed [pid_pkg::DATA_W-1:0] ki_reg;
    logic signed [pid_pkg::DATA_W-1:0] kd_over_ts_reg;
    logic [pid_pkg::ST_W-1:0]          sample_time_reg;
    logic signed [pid_pkg::DATA_W-1:0] sat_min_reg;
    logic signed [pid_pkg::DATA_W-1:0] sat_max_reg;
    logic signed [pid_pkg::DATA_W-1:0] integ_start_reg;
    logic signed [pid_pkg::DATA_W-1:0] deriv_start_reg;

    // Controller state and working registers
    state_t                             state_reg;
    term_kind_t                         term_reg;
    term_kind_t                         wb_kind_reg;
    phase_t                             phase_reg;
    logic                               wb_pending_reg;
    logic signed [pid_pkg::ACC_W-1:0]   acc_reg;
    logic signed [pid_pkg::DATA_W-1:0]  prev_reg;
    logic signed [pid_pkg::DATA_W-1:0]  s_reg;
    logic signed [pid_pkg::DIFF_W-1:0]  diff_reg;
    logic signed [pid_pkg::SUM_W-1:0]   sum_reg;
    logic signed [pid_pkg::DATA_W-1:0]  drive_reg;
    logic                               integrated_reg;
    logic                               clipped_reg;
    logic                               out_valid_reg;

    pid_pkg::mac_ctrl_t                 mac_ctrl;
    logic signed [pid_pkg::OPA_W-1:0]   op_a;
    logic signed [pid_pkg::OPB_W-1:0]   op_b;
    logic signed [pid_pkg::TERM_W-1:0]  term;
    logic                               accept;
    logic                               in_window;
    logic                               wb_fire;
    logic signed [pid_pkg::DIFF_W-1:0]  diff_next;
    logic signed [pid_pkg::SUM_W-1:0]   acc_sum;
    logic signed [pid_pkg::ACC_W-1:0]   acc_next;
    logic signed [pid_pkg::SUM_W-1:0]   sum_next;
    logic signed [pid_pkg::DATA_W-1:0]  drive_next;
    logic                               clipped_next;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg          <= '0;
            ki_reg          <= '0;
            kd_over_ts_reg  <= '0;
            sample_time_reg <= pid_pkg::SAMPLE_TIME_RST;
            sat_min_reg     <= {1'b1, {(pid_pkg::DATA_W-1){1'b0}}};
            sat_max_reg     <= {1'b0, {(pid_pkg::DATA_W-1){1'b1}}};
            integ_start_reg <= '0;
            deriv_start_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pid_pkg::CFG_KP:          kp_reg          <= cfg_data;
                pid_pkg::CFG_KI:          ki_reg          <= cfg_data;
                pid_pkg::CFG_KD_OVER_TS:  kd_over_ts_reg  <= cfg_data;
                pid_pkg::CFG_SAMPLE_TIME: sample_time_reg <= cfg_data[pid_pkg::ST_W-1:0];
                pid_pkg::CFG_SAT_MIN:     sat_min_reg     <= cfg_data;
                pid_pkg::CFG_SAT_MAX:     sat_max_reg     <= cfg_data;
                pid_pkg::CFG_INTEG_START: integ_start_reg <= cfg_data;
                pid_pkg::CFG_DERIV_START: deriv_start_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_window = (error_sample > sat_min_reg) && (error_sample < sat_max_reg);
    assign diff_next = {error_sample[pid_pkg::DATA_W-1], error_sample}
                     - {prev_reg[pid_pkg::DATA_W-1], prev_reg};

    // Select multiplier operands for the current term
    always_comb
    begin
        unique case (term_reg)
            T_INC:
            begin
                op_a = {{(pid_pkg::OPA_W-pid_pkg::DATA_W){s_reg[pid_pkg::DATA_W-1]}}, s_reg};
                op_b = {1'b0, sample_time_reg};
            end
            T_D:
            begin
                op_a = {{(pid_pkg::OPA_W-pid_pkg::DIFF_W){diff_reg[pid_pkg::DIFF_W-1]}},
                        diff_reg};
                op_b = kd_over_ts_reg;
            end
            T_P:
            begin
                op_a = {{(pid_pkg::OPA_W-pid_pkg::DATA_W){s_reg[pid_pkg::DATA_W-1]}}, s_reg};
                op_b = kp_reg;
            end
            T_I:
            begin
                op_a = {acc_reg[pid_pkg::ACC_W-1], acc_reg};
                op_b = ki_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Sequence the multiplier passes
    assign mac_ctrl.lo_en      = (state_reg == S_MUL) && (phase_reg == PH_LO);
    assign mac_ctrl.hi_en      = (state_reg == S_MUL) && (phase_reg == PH_HI);
    assign mac_ctrl.combine_en = (state_reg == S_MUL) && (phase_reg == PH_COMBINE);

    pid_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .term (term)
    );

    // Retire the finished term while the next one starts, or in the finish state
    assign wb_fire = wb_pending_reg
                  && (((state_reg == S_MUL) && (phase_reg == PH_LO)) || (state_reg == S_FINISH));

    // Saturate the integral update to the accumulator range
    assign acc_sum = {{(pid_pkg::SUM_W-pid_pkg::ACC_W){acc_reg[pid_pkg::ACC_W-1]}}, acc_reg}
                   + {term[pid_pkg::TERM_W-1], term};
    always_comb
    begin
        priority if (acc_sum > pid_pkg::ACC_MAX)
        begin
            acc_next = pid_pkg::ACC_MAX[pid_pkg::ACC_W-1:0];
        end
        else if (acc_sum < pid_pkg::ACC_MIN)
        begin
            acc_next = pid_pkg::ACC_MIN[pid_pkg::ACC_W-1:0];
        end
        else
        begin
            acc_next = acc_sum[pid_pkg::ACC_W-1:0];
        end
    end

    // Add the term into the drive sum and clip to the data range
    assign sum_next = sum_reg + {term[pid_pkg::TERM_W-1], term};
    always_comb
    begin
        priority if (sum_next > pid_pkg::DATA_MAX)
        begin
            drive_next   = pid_pkg::DATA_MAX[pid_pkg::DATA_W-1:0];
            clipped_next = 1'b1;
        end
        else if (sum_next < pid_pkg::DATA_MIN)
        begin
            drive_next   = pid_pkg::DATA_MIN[pid_pkg::DATA_W-1:0];
            clipped_next = 1'b1;
        end
        else
        begin
            drive_next   = sum_next[pid_pkg::DATA_W-1:0];
            clipped_next = 1'b0;
        end
    end

    // Hold state, working registers and the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            term_reg       <= T_INC;
            wb_kind_reg    <= T_INC;
            phase_reg      <= PH_LO;
            wb_pending_reg <= 1'b0;
            acc_reg        <= '0;
            prev_reg       <= '0;
            s_reg          <= '0;
            diff_reg       <= '0;
            sum_reg        <= '0;
            drive_reg      <= '0;
            out_valid_reg  <= 1'b0;
            integrated_reg <= 1'b0;
            clipped_reg    <= 1'b0;
        end
        else
        begin
            if (wb_fire)
            begin
                wb_pending_reg <= 1'b0;
                if (wb_kind_reg == T_INC)
                begin
                    acc_reg <= acc_next;
                end
                else
                begin
                    sum_reg <= sum_next;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd == pid_pkg::CMD_LOAD)
                        begin
                            acc_reg <= {{(pid_pkg::ACC_W-pid_pkg::DATA_W)
                                         {integ_start_reg[pid_pkg::DATA_W-1]}},
                                        integ_start_reg};
                            prev_reg       <= deriv_start_reg;
                            drive_reg      <= '0;
                            integrated_reg <= 1'b0;
                            clipped_reg    <= 1'b0;
                            out_valid_reg  <= 1'b1;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            s_reg          <= error_sample;
                            diff_reg       <= diff_next;
                            prev_reg       <= error_sample;
                            sum_reg        <= '0;
                            integrated_reg <= in_window;
                            term_reg       <= in_window ? T_INC : T_D;
                            phase_reg      <= PH_LO;
                            state_reg      <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    unique case (phase_reg)
                        PH_LO:
                        begin
                            phase_reg <= PH_HI;
                        end
                        PH_HI:
                        begin
                            phase_reg <= PH_COMBINE;
                        end
                        PH_COMBINE:
                        begin
                            wb_pending_reg <= 1'b1;
                            wb_kind_reg    <= term_reg;
                            phase_reg      <= PH_LO;
                            unique case (term_reg)
                                T_INC:   term_reg <= T_D;
                                T_D:     term_reg <= T_P;
                                T_P:     term_reg <= T_I;
                                T_I:     state_reg <= S_FINISH;
                                default: term_reg <= T_INC;
                            endcase
                        end
                        default:
                        begin
                            phase_reg <= PH_LO;
                        end
                    endcase
                end
                S_FINISH:
                begin
                    drive_reg     <= drive_next;
                    clipped_reg   <= clipped_next;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign drive      = drive_reg;
    assign integrated = integrated_reg;
    assign clipped    = clipped_reg;

    // A result is never pending while the block takes requests
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
    else $error("result pending while request side is open");

    // A load request answers in the next cycle with an all-zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (cmd == pid_pkg::CMD_LOAD))
        |=> (out_valid && (drive == '0) && !integrated && !clipped))
    else $error("load request result is wrong");

    // A clipped drive sits on one of the data range limits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clipped)
        |-> ((drive == pid_pkg::DATA_MAX[pid_pkg::DATA_W-1:0])
          || (drive == pid_pkg::DATA_MIN[pid_pkg::DATA_W-1:0])))
    else $error("clipped drive not at a limit");

    // The multiplier runs only while a process request is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (mac_ctrl.lo_en || mac_ctrl.hi_en || mac_ctrl.combine_en) |-> in_stall)
    else $error("multiplier active while idle");

endmodule
